@@ rtl/core/dual_channel_pid_controller_top_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the dual channel PID controller
// Shared concurrent assertion forms used by the top-level RTL module.
// ---------------------------------------------------------------------------
`ifndef DUAL_CHANNEL_PID_CONTROLLER_TOP_DEFINES_SVH
`define DUAL_CHANNEL_PID_CONTROLLER_TOP_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define DCPID_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define DCPID_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/dcpid_pkg.sv @@
// ---------------------------------------------------------------------------
// dcpid_pkg
// Beat types, register map and constants of the dual channel PID controller.
// ---------------------------------------------------------------------------
package dcpid_pkg;

   // Microseconds per second
   localparam logic [19:0] USEC = 20'd1000000;

   // Byte address width of the register port
   localparam int CSR_AW = 5;

   // Register map, one word per register
   typedef enum logic [2:0] {
      REG_KP_CH0,
      REG_KI_CH0,
      REG_KD_CH0,
      REG_KP_CH1,
      REG_KI_CH1,
      REG_KD_CH1,
      REG_LIMIT
   } reg_index_type;

   // Reset values of the registers
   localparam logic signed [31:0] KP_CH0_RESET = 32'sd3276800;
   localparam logic signed [31:0] KI_CH0_RESET = 32'sd3277;
   localparam logic signed [31:0] KD_CH0_RESET = 32'sd655360;
   localparam logic signed [31:0] KP_CH1_RESET = 32'sd2621440;
   localparam logic signed [31:0] KI_CH1_RESET = 32'sd3277;
   localparam logic signed [31:0] KD_CH1_RESET = 32'sd327680;
   localparam logic [15:0]        LIMIT_RESET  = 16'd1500;

   // Input beat
   typedef struct packed {
      logic               channel;
      logic signed [15:0] setpoint;
      logic signed [15:0] measured;
      logic [31:0]        timestamp_us;
   } req_data_type;

   // Result beat
   typedef struct packed {
      logic               out_channel;
      logic signed [31:0] control;
      logic               saturated;
   } rsp_data_type;

   // Q16.16 gains of one channel
   typedef struct packed {
      logic signed [31:0] kp;
      logic signed [31:0] ki;
      logic signed [31:0] kd;
   } gain_set_type;

   // Configuration seen by the datapath
   typedef struct packed {
      gain_set_type [1:0] gains;
      logic [15:0]        integral_limit;
   } csr_cfg_type;

endpackage

@@ rtl/core/dual_channel_pid_controller_top.sv @@
// A new input beat is accepted only once the previous result beat is loaded.
// The two passes of the shared integral divider run one after the other.
// The derivative divider runs in parallel with the first pass.
// Reset: synchronous; gains and clamp return to defaults, per channel state
// reads as zero through valid bits until the channel is first written.
// ---------------------------------------------------------------------------
// dual_channel_pid_controller_top
// Two-channel PID controller with integral clamp; per channel state in a RAM.
// ---------------------------------------------------------------------------
`include "dual_channel_pid_controller_top_defines.svh"

module dual_channel_pid_controller_top #(
   parameter int CHANNELS = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  dcpid_pkg::req_data_type      req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output dcpid_pkg::rsp_data_type      rsp_data,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [dcpid_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);

   import dcpid_pkg::*;

   localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [AW-1:0] LAST_IDX = AW'(CHANNELS - 1);

   typedef struct packed {
      logic [31:0]        last_time;
      logic signed [16:0] last_error;
      logic signed [47:0] error_integral;
   } entry_type;

   localparam int EW = $bits(entry_type);

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_M_EDT, S_M_LIM, S_M_DE, S_CLAMP, S_DIV1, S_WAIT1,
      S_M_KIR, S_DIV2, S_M_KP, S_M_KQ, S_ACC_KQ, S_M_KD, S_ACC_KD, S_FIN
   } state_type;

   // -------------------------------------------------------------------
   // Configuration
   // -------------------------------------------------------------------
   csr_cfg_type  cfg;
   gain_set_type gain;

   dcpid_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // -------------------------------------------------------------------
   // Registers
   // -------------------------------------------------------------------
   state_type           state_ff;
   logic                rsp_valid_ff;
   rsp_data_type        rsp_data_ff;
   logic [CHANNELS-1:0] valid_ff;
   logic                rd_valid_ff;

   logic                ch_ff;
   logic [AW-1:0]       idx_ff;
   logic [31:0]         ts_ff;
   logic signed [16:0]  e_ff;
   logic [31:0]         dt_ff;
   logic                dt_zero_ff;
   logic signed [17:0]  de_ff;
   logic signed [47:0]  iold_ff;
   logic signed [49:0]  isum_ff;
   logic [35:0]         lim_ff;
   logic signed [36:0]  integ_ff;
   logic                de_neg_ff;
   logic                kir_neg_ff;
   logic signed [16:0]  q_ff;
   logic signed [65:0]  prod_ff;
   logic signed [63:0]  acc_ff;
   logic signed [31:0]  edot_ff;
   logic                edot_sat_ff;

   // -------------------------------------------------------------------
   // Handshake and state memory
   // -------------------------------------------------------------------
   logic          req_accept;
   logic [AW-1:0] idx_in;
   logic          ram_rd_en;
   logic          ram_wr_en;
   logic [EW-1:0] ram_rd_data;
   entry_type     wr_entry;
   entry_type     rd_entry;
   logic          rsp_load;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign idx_in     = (CHANNELS > 1) ? AW'(req_data.channel) : LAST_IDX;
   assign ram_rd_en  = req_accept;
   assign ram_wr_en  = (state_ff == S_DIV1);

   assign wr_entry.last_time      = ts_ff;
   assign wr_entry.last_error     = e_ff;
   assign wr_entry.error_integral = 48'(integ_ff);

   dcpid_ram #(
      .WIDTH (EW),
      .DEPTH (CHANNELS),
      .AW    (AW)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (idx_ff),
      .wr_data (wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_in),
      .rd_data (ram_rd_data)
   );

   // Unwritten entries read as zero
   assign rd_entry = rd_valid_ff ? entry_type'(ram_rd_data) : '0;
   assign gain     = cfg.gains[ch_ff];

   // -------------------------------------------------------------------
   // Shared multiplier operand select
   // -------------------------------------------------------------------
   logic signed [32:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [65:0] prod_in;
   logic               mul_en;
   logic signed [20:0] r_in;
   logic signed [16:0] q_in;
   logic signed [31:0] edot_in;
   logic               edot_sat_in;

   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      mul_en = 1'b1;
      case (state_ff)
         S_M_EDT: begin
            mul_a = 33'(e_ff);
            mul_b = {1'b0, dt_ff};
         end
         S_M_LIM: begin
            mul_a = {17'd0, cfg.integral_limit};
            mul_b = 33'(USEC);
         end
         S_M_DE: begin
            mul_a = 33'(de_ff);
            mul_b = 33'(USEC);
         end
         S_M_KIR: begin
            mul_a = 33'(gain.ki);
            mul_b = 33'(r_in);
         end
         S_M_KP: begin
            mul_a = 33'(gain.kp);
            mul_b = 33'(e_ff);
         end
         S_M_KQ: begin
            mul_a = 33'(gain.ki);
            mul_b = 33'(q_ff);
         end
         S_M_KD: begin
            mul_a = 33'(gain.kd);
            mul_b = 33'(edot_in);
         end
         default: mul_en = 1'b0;
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // -------------------------------------------------------------------
   // Dividers
   // -------------------------------------------------------------------
   logic [65:0]  prod_mag;
   logic [35:0]  integ_mag;
   logic         div_a_start;
   logic         div_a_busy;
   logic [37:0]  quo_a;
   logic [31:0]  rem_a;
   logic         div_b_start;
   logic         div_b_busy;
   logic [19:0]  num_hi_b;
   logic [31:0]  num_lo_b;
   logic [31:0]  quo_b;
   logic [19:0]  rem_b;

   assign prod_mag  = prod_ff[65] ? 66'(-prod_ff) : 66'(prod_ff);
   assign integ_mag = integ_ff[36] ? 36'(-integ_ff) : 36'(integ_ff);

   // Derivative: |de * 1e6| / dt
   assign div_a_start = (state_ff == S_CLAMP) && !dt_zero_ff;

   dcpid_div #(
      .QW (38),
      .VW (32)
   ) u_div_edot (
      .clock  (clock),
      .reset  (reset),
      .start  (div_a_start),
      .num_hi ('0),
      .num_lo (prod_mag[37:0]),
      .den    (dt_ff),
      .busy   (div_a_busy),
      .quo    (quo_a),
      .rem    (rem_a)
   );

   // Integral: |integ| / 1e6, then |ki * r| / 1e6
   assign div_b_start = (state_ff == S_DIV1) || (state_ff == S_DIV2);
   assign num_hi_b    = (state_ff == S_DIV1) ? {16'd0, integ_mag[35:32]} : prod_mag[51:32];
   assign num_lo_b    = (state_ff == S_DIV1) ? integ_mag[31:0] : prod_mag[31:0];

   dcpid_div #(
      .QW (32),
      .VW (20)
   ) u_div_integ (
      .clock  (clock),
      .reset  (reset),
      .start  (div_b_start),
      .num_hi (num_hi_b),
      .num_lo (num_lo_b),
      .den    (USEC),
      .busy   (div_b_busy),
      .quo    (quo_b),
      .rem    (rem_b)
   );

   // -------------------------------------------------------------------
   // Datapath next values
   // -------------------------------------------------------------------
   entry_type          ent_unused;
   logic [31:0]        dt_in;
   logic signed [17:0] de_in;
   logic signed [49:0] isum_in;
   logic signed [49:0] lim_s;
   logic signed [49:0] integ_wide;
   logic signed [36:0] integ_in;
   logic signed [31:0] t_in;
   logic signed [47:0] shifted;
   logic signed [31:0] control_in;
   logic               out_sat_in;

   assign ent_unused = rd_entry;
   assign dt_in      = ts_ff - ent_unused.last_time;
   assign de_in      = 18'(e_ff) - 18'(ent_unused.last_error);
   assign isum_in    = 50'(iold_ff) + prod_ff[49:0];
   assign lim_s      = signed'({14'd0, lim_ff});
   assign integ_wide = 50'(integ_ff);

   // Clamp the integral symmetrically
   always_comb begin
      if (isum_ff > lim_s) begin
         integ_in = 37'(lim_s);
      end else if (isum_ff < -lim_s) begin
         integ_in = 37'(-lim_s);
      end else begin
         integ_in = 37'(isum_ff);
      end
   end

   // Signed quotient and remainder of integ / 1e6
   assign q_in = integ_ff[36] ? -signed'({1'b0, quo_b[15:0]}) : signed'({1'b0, quo_b[15:0]});
   assign r_in = integ_ff[36] ? -signed'({1'b0, rem_b}) : signed'({1'b0, rem_b});

   // Truncated ki * r / 1e6
   assign t_in = kir_neg_ff ? -signed'(quo_b) : signed'(quo_b);

   // Derivative with zero step and saturation
   always_comb begin
      edot_in     = '0;
      edot_sat_in = 1'b0;
      if (!dt_zero_ff) begin
         if (!de_neg_ff) begin
            if (|quo_a[37:31]) begin
               edot_in     = 32'sh7FFFFFFF;
               edot_sat_in = 1'b1;
            end else begin
               edot_in = signed'(quo_a[31:0]);
            end
         end else begin
            if (quo_a > 38'd2147483648) begin
               edot_in     = 32'sh80000000;
               edot_sat_in = 1'b1;
            end else begin
               edot_in = -signed'(quo_a[31:0]);
            end
         end
      end
   end

   // Floor shift by 16 and saturate
   assign shifted = acc_ff[63:16];

   always_comb begin
      out_sat_in = 1'b0;
      control_in = 32'(shifted);
      if (shifted > 48'sd2147483647) begin
         control_in = 32'sh7FFFFFFF;
         out_sat_in = 1'b1;
      end else if (shifted < -48'sd2147483648) begin
         control_in = 32'sh80000000;
         out_sat_in = 1'b1;
      end
   end

   assign rsp_load = (state_ff == S_FIN) && (!rsp_valid_ff || !rsp_stall);

   // -------------------------------------------------------------------
   // Sequencer, datapath registers and result register
   // -------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         if (mul_en) begin
            prod_ff <= prod_in;
         end

         // Drop the result beat once taken
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  ch_ff       <= req_data.channel;
                  idx_ff      <= idx_in;
                  ts_ff       <= req_data.timestamp_us;
                  e_ff        <= 17'(req_data.setpoint) - 17'(req_data.measured);
                  rd_valid_ff <= valid_ff[idx_in];
                  state_ff    <= S_READ;
               end
            end
            S_READ: begin
               dt_ff      <= dt_in;
               dt_zero_ff <= (dt_in == '0);
               de_ff      <= de_in;
               iold_ff    <= ent_unused.error_integral;
               state_ff   <= S_M_EDT;
            end
            S_M_EDT: begin
               state_ff <= S_M_LIM;
            end
            S_M_LIM: begin
               isum_ff  <= isum_in;
               state_ff <= S_M_DE;
            end
            S_M_DE: begin
               lim_ff   <= prod_ff[35:0];
               state_ff <= S_CLAMP;
            end
            S_CLAMP: begin
               integ_ff  <= integ_in;
               de_neg_ff <= de_ff[17];
               state_ff  <= S_DIV1;
            end
            S_DIV1: begin
               // Write back the channel state
               valid_ff[idx_ff] <= 1'b1;
               state_ff         <= S_WAIT1;
            end
            S_WAIT1: begin
               if (!div_b_busy) begin
                  state_ff <= S_M_KIR;
               end
            end
            S_M_KIR: begin
               q_ff     <= q_in;
               state_ff <= S_DIV2;
            end
            S_DIV2: begin
               kir_neg_ff <= prod_ff[65];
               state_ff   <= S_M_KP;
            end
            S_M_KP: begin
               state_ff <= S_M_KQ;
            end
            S_M_KQ: begin
               acc_ff   <= prod_ff[63:0];
               state_ff <= S_ACC_KQ;
            end
            S_ACC_KQ: begin
               acc_ff   <= acc_ff + prod_ff[63:0];
               state_ff <= S_M_KD;
            end
            S_M_KD: begin
               // Hold until the derivative is ready
               if (!div_a_busy) begin
                  edot_ff     <= edot_in;
                  edot_sat_ff <= edot_sat_in;
                  state_ff    <= S_ACC_KD;
               end
            end
            S_ACC_KD: begin
               // Add kd * edot and the integral term once its divide is done
               if (!div_b_busy) begin
                  acc_ff   <= acc_ff + prod_ff[63:0] + 64'(t_in);
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               if (rsp_load) begin
                  rsp_valid_ff            <= 1'b1;
                  rsp_data_ff.out_channel <= ch_ff;
                  rsp_data_ff.control     <= control_in;
                  rsp_data_ff.saturated   <= edot_sat_ff | out_sat_in;
                  state_ff                <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // -------------------------------------------------------------------
   // Assertions
   // -------------------------------------------------------------------
   `DCPID_ASSERT_IMPLIES(a_integral_clamped, clock, reset, ram_wr_en, (integ_wide <= lim_s) && (integ_wide >= -lim_s), "stored integral beyond clamp")
   `DCPID_ASSERT_IMPLIES(a_div_start_idle, clock, reset, div_a_start || div_b_start, !(div_a_start && div_a_busy) && !(div_b_start && div_b_busy), "divider restarted while busy")
   `DCPID_ASSERT_NEXT(a_div_b_runs, clock, reset, div_b_start, div_b_busy, "integral divider did not start")
   `DCPID_ASSERT_IMPLIES(a_load_dividers_idle, clock, reset, rsp_load, !div_a_busy && !div_b_busy && (edot_ff == edot_ff), "result loaded while a divide is running")

endmodule

@@ rtl/core/dcpid_ram.sv @@
// ---------------------------------------------------------------------------
// dcpid_ram
// Generic single write port, single read port RAM with registered read data.
// ---------------------------------------------------------------------------
module dcpid_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/dcpid_div.sv @@
// ---------------------------------------------------------------------------
// dcpid_div
// Unsigned restoring divider, two quotient bits per cycle.
// The dividend is {num_hi, num_lo}; num_hi must be below den.
// ---------------------------------------------------------------------------
module dcpid_div #(
   parameter int QW = 32,
   parameter int VW = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [VW-1:0] num_hi,
   input  logic [QW-1:0] num_lo,
   input  logic [VW-1:0] den,
   output logic          busy,
   output logic [QW-1:0] quo,
   output logic [VW-1:0] rem
);

   localparam int STEPS = QW / 2;
   localparam int CW    = $clog2(STEPS + 1);

   logic [CW-1:0] cnt_ff;
   logic [CW-1:0] cnt_in;
   logic [VW-1:0] rem_ff;
   logic [VW-1:0] rem_in;
   logic [QW-1:0] quo_ff;
   logic [QW-1:0] quo_in;
   logic [VW-1:0] den_ff;

   // Two restoring steps: shift in a dividend bit, subtract when it fits
   always_comb begin
      logic [VW:0]   trial;
      logic [VW-1:0] r;
      logic [QW-1:0] q;
      r = rem_ff;
      q = quo_ff;
      for (int k = 0; k < 2; k++) begin
         trial = {r, q[QW-1]};
         q     = {q[QW-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            trial = trial - {1'b0, den_ff};
            q[0]  = 1'b1;
         end
         r = trial[VW-1:0];
      end
      rem_in = r;
      quo_in = q;
      cnt_in = cnt_ff - CW'(1);
   end

   // Load on start, iterate while busy
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= CW'(STEPS);
         rem_ff <= num_hi;
         quo_ff <= num_lo;
         den_ff <= den;
      end else if (busy) begin
         cnt_ff <= cnt_in;
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign busy = (cnt_ff != '0);
   assign quo  = quo_ff;
   assign rem  = rem_ff;

endmodule

@@ rtl/core/dcpid_csr.sv @@
// ---------------------------------------------------------------------------
// dcpid_csr
// APB-style register file holding the gains and the integral clamp.
// ---------------------------------------------------------------------------
module dcpid_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [dcpid_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready,
   output dcpid_pkg::csr_cfg_type      cfg
);

   import dcpid_pkg::*;

   csr_cfg_type   cfg_ff;
   reg_index_type idx;
   logic          wr_en;

   assign idx   = reg_index_type'(csr_paddr[CSR_AW-1:2]);
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Register writes; an address past the map is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gains[0].kp     <= KP_CH0_RESET;
         cfg_ff.gains[0].ki     <= KI_CH0_RESET;
         cfg_ff.gains[0].kd     <= KD_CH0_RESET;
         cfg_ff.gains[1].kp     <= KP_CH1_RESET;
         cfg_ff.gains[1].ki     <= KI_CH1_RESET;
         cfg_ff.gains[1].kd     <= KD_CH1_RESET;
         cfg_ff.integral_limit  <= LIMIT_RESET;
      end else if (wr_en) begin
         unique case (idx)
            REG_KP_CH0: cfg_ff.gains[0].kp <= csr_pwdata;
            REG_KI_CH0: cfg_ff.gains[0].ki <= csr_pwdata;
            REG_KD_CH0: cfg_ff.gains[0].kd <= csr_pwdata;
            REG_KP_CH1: cfg_ff.gains[1].kp <= csr_pwdata;
            REG_KI_CH1: cfg_ff.gains[1].ki <= csr_pwdata;
            REG_KD_CH1: cfg_ff.gains[1].kd <= csr_pwdata;
            REG_LIMIT:  cfg_ff.integral_limit <= csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // Read mux
   always_comb begin
      unique case (idx)
         REG_KP_CH0: csr_prdata = cfg_ff.gains[0].kp;
         REG_KI_CH0: csr_prdata = cfg_ff.gains[0].ki;
         REG_KD_CH0: csr_prdata = cfg_ff.gains[0].kd;
         REG_KP_CH1: csr_prdata = cfg_ff.gains[1].kp;
         REG_KI_CH1: csr_prdata = cfg_ff.gains[1].ki;
         REG_KD_CH1: csr_prdata = cfg_ff.gains[1].kd;
         REG_LIMIT:  csr_prdata = {16'd0, cfg_ff.integral_limit};
         default:    csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule
